// ----- hdl/rtps_pkg.sv -----
// ----------------------------------------------------------------------------
// RTP receive statistics package
// Shared constants, result codes and the header item type.
// ----------------------------------------------------------------------------
package rtps_pkg;

  localparam logic [31:0] STUN_COOKIE = 32'h2112_A442;
  localparam logic [6:0]  CN_TYPE     = 7'd13;
  localparam logic [6:0]  CN_TYPE_OLD = 7'd19;
  localparam logic [6:0]  FIXED_HDR   = 7'd12;
  localparam logic [15:0] SEQ_NONE    = 16'hFFFF;
  localparam logic [32:0] JIT_ROUND   = 33'd8;
  localparam int          JIT_SHIFT   = 4;

  typedef enum logic [2:0] {
    VERDICT_STUN       = 3'd0,
    VERDICT_DROP       = 3'd1,
    VERDICT_CN_START   = 3'd2,
    VERDICT_CN_ONGOING = 3'd3,
    VERDICT_MEDIA      = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [6:0]  pl_type;
    logic [15:0] seq_number;
    logic [31:0] rtp_timestamp;
    logic [3:0]  csrc_count;
    logic [15:0] packet_len;
  } hdr_item_t;

endpackage

// ----- hdl/rtps_in_if.sv -----
// ----------------------------------------------------------------------------
// RTP header request channel
// Valid/ready channel carrying one parsed packet header per request.
// ----------------------------------------------------------------------------
interface rtps_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] magic_word;
  logic [6:0]  pl_type;
  logic [15:0] seq_number;
  logic [31:0] rtp_timestamp;
  logic [3:0]  csrc_count;
  logic [15:0] packet_len;

  modport source (
    output valid, magic_word, pl_type, seq_number, rtp_timestamp,
           csrc_count, packet_len,
    input  ready
  );
  modport sink (
    input  valid, magic_word, pl_type, seq_number, rtp_timestamp,
           csrc_count, packet_len,
    output ready
  );
endinterface

// ----- hdl/rtps_out_if.sv -----
// ----------------------------------------------------------------------------
// RTP statistics result channel
// Valid/ready channel carrying the verdict and statistics for one packet.
// ----------------------------------------------------------------------------
interface rtps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [6:0]  pl_offset;
  logic [15:0] payload_bytes;
  logic        seq_gap;
  logic [31:0] jitter_estimate;
  logic [31:0] packet_count;
  logic [31:0] byte_count;
  logic [31:0] missing_count;
  logic        noise_active;

  modport source (
    output valid, verdict, pl_offset, payload_bytes, seq_gap,
           jitter_estimate, packet_count, byte_count, missing_count,
           noise_active,
    input  ready
  );
  modport sink (
    input  valid, verdict, pl_offset, payload_bytes, seq_gap,
           jitter_estimate, packet_count, byte_count, missing_count,
           noise_active,
    output ready
  );
endinterface

// ----- hdl/rtps_in_reg.sv -----
// ----------------------------------------------------------------------------
// RTP header input register
// Captures one header request and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module rtps_in_reg
  import rtps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rtps_in_if.sink     in_ch,
  input  logic        advance,
  output logic        item_valid,
  output hdr_item_t   item
);

  logic      valid_r;
  hdr_item_t item_r;

  assign in_ch.ready = !valid_r || advance;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.magic_word    <= in_ch.magic_word;
      item_r.pl_type       <= in_ch.pl_type;
      item_r.seq_number    <= in_ch.seq_number;
      item_r.rtp_timestamp <= in_ch.rtp_timestamp;
      item_r.csrc_count    <= in_ch.csrc_count;
      item_r.packet_len    <= in_ch.packet_len;
    end
  end

endmodule

// ----- hdl/rtps_core.sv -----
// ----------------------------------------------------------------------------
// RTP statistics update stage
// Classifies the held header, updates the receive state and registers the
// result.
// ----------------------------------------------------------------------------
module rtps_core
  import rtps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        item_valid,
  input  hdr_item_t   item,
  output logic        advance,
  rtps_out_if.source  out_ch
);

  logic [6:0]  codec_r;
  logic [15:0] prev_seq_r,  prev_seq_nxt;
  logic [31:0] prev_ts_r,   prev_ts_nxt;
  logic [31:0] prev_ia_r,   prev_ia_nxt;
  logic [31:0] jitter_r,    jitter_nxt;
  logic [31:0] packets_r,   packets_nxt;
  logic [31:0] bytes_r,     bytes_nxt;
  logic [31:0] gaps_r,      gaps_nxt;
  logic        noise_r,     noise_nxt;

  logic        out_valid_r;
  verdict_t    verdict_r,   verdict_nxt;
  logic [6:0]  offset_r,    offset_nxt;
  logic [15:0] pbytes_r,    pbytes_nxt;
  logic        gap_r,       gap_nxt;

  logic        capture;
  logic        is_stun;
  logic        is_media;
  logic        is_cn;
  logic [6:0]  offset;
  logic        gap;
  logic [31:0] ia;
  logic [31:0] d;
  logic [31:0] decay;
  logic [32:0] jit_round;

  assign advance = !out_valid_r || out_ch.ready;
  assign capture = item_valid && advance;

  always_comb begin
    is_stun  = item.magic_word == STUN_COOKIE;
    is_media = !is_stun && (item.pl_type == codec_r);
    is_cn    = !is_stun && !is_media &&
               ((item.pl_type == CN_TYPE) || (item.pl_type == CN_TYPE_OLD));

    offset   = FIXED_HDR + {1'b0, item.csrc_count, 2'b00};
    gap      = (prev_seq_r != SEQ_NONE) && ((prev_seq_r + 16'd1) != item.seq_number);

    ia        = item.rtp_timestamp - prev_ts_r;
    d         = (ia < prev_ia_r) ? (prev_ia_r - ia) : (ia - prev_ia_r);
    jit_round = {1'b0, jitter_r} + JIT_ROUND;
    decay     = 32'(jit_round >> JIT_SHIFT);

    prev_seq_nxt = prev_seq_r;
    prev_ts_nxt  = prev_ts_r;
    prev_ia_nxt  = prev_ia_r;
    jitter_nxt   = jitter_r;
    packets_nxt  = packets_r;
    bytes_nxt    = bytes_r;
    gaps_nxt     = gaps_r;
    noise_nxt    = noise_r;
    verdict_nxt  = VERDICT_DROP;
    offset_nxt   = 7'd0;
    pbytes_nxt   = 16'd0;
    gap_nxt      = 1'b0;

    if (is_stun) begin
      verdict_nxt = VERDICT_STUN;
    end else if (is_cn) begin
      verdict_nxt = noise_r ? VERDICT_CN_ONGOING : VERDICT_CN_START;
      noise_nxt   = 1'b1;
    end else if (is_media) begin
      verdict_nxt  = VERDICT_MEDIA;
      noise_nxt    = 1'b0;
      packets_nxt  = packets_r + 32'd1;
      bytes_nxt    = bytes_r + {16'd0, item.packet_len};
      gaps_nxt     = gaps_r + {31'd0, gap};
      gap_nxt      = gap;
      prev_seq_nxt = item.seq_number;
      if (prev_ts_r != 32'd0) begin
        if (prev_ia_r != 32'd0) begin
          jitter_nxt = jitter_r + d - decay;
        end
        prev_ia_nxt = ia;
      end
      prev_ts_nxt = item.rtp_timestamp;
      offset_nxt  = offset;
      pbytes_nxt  = (item.packet_len > {9'd0, offset}) ?
                    (item.packet_len - {9'd0, offset}) : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= 7'd0;
    end else if (cfg_we) begin
      codec_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_seq_r  <= SEQ_NONE;
      prev_ts_r   <= 32'd0;
      prev_ia_r   <= 32'd0;
      jitter_r    <= 32'd0;
      packets_r   <= 32'd0;
      bytes_r     <= 32'd0;
      gaps_r      <= 32'd0;
      noise_r     <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= item_valid;
      end
      if (capture) begin
        prev_seq_r <= prev_seq_nxt;
        prev_ts_r  <= prev_ts_nxt;
        prev_ia_r  <= prev_ia_nxt;
        jitter_r   <= jitter_nxt;
        packets_r  <= packets_nxt;
        bytes_r    <= bytes_nxt;
        gaps_r     <= gaps_nxt;
        noise_r    <= noise_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      verdict_r <= verdict_nxt;
      offset_r  <= offset_nxt;
      pbytes_r  <= pbytes_nxt;
      gap_r     <= gap_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.verdict         = verdict_r;
  assign out_ch.pl_offset       = offset_r;
  assign out_ch.payload_bytes   = pbytes_r;
  assign out_ch.seq_gap         = gap_r;
  assign out_ch.jitter_estimate = jitter_r;
  assign out_ch.packet_count    = packets_r;
  assign out_ch.byte_count      = bytes_r;
  assign out_ch.missing_count   = gaps_r;
  assign out_ch.noise_active    = noise_r;

endmodule

// ----- hdl/rtp_receive_stats.sv -----
// ----------------------------------------------------------------------------
// RTP receive statistics
// Per-packet classification with loss counting and interarrival jitter.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake        Carries
//  in_ch     in   valid / ready    one parsed RTP header per request
//  out_ch    out  valid / ready    verdict, payload extent and statistics
//  cfg_*     in   write enable     codec payload type
//
// One request is accepted per cycle while the result channel is not stalled;
// its result passes through the input register and then the result register.
// The statistics update is a single pass of logic between those registers.
// A stalled result holds the result register and the input register fills
// behind it; the counters only move when a new result is captured.
// Reset is synchronous and leaves the block ready in the first cycle after.
module rtp_receive_stats
  import rtps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  rtps_in_if.sink     in_ch,
  rtps_out_if.source  out_ch
);

  logic      advance;
  logic      item_valid;
  hdr_item_t item;

  rtps_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rtps_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_ch     (out_ch)
  );

endmodule

// ----- hdl/rtps_checker.sv -----
// ----------------------------------------------------------------------------
// RTP receive statistics checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rtps_checker
  import rtps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_verdict,
  input  logic [6:0]  out_pl_offset,
  input  logic [15:0] out_payload_bytes,
  input  logic        out_seq_gap,
  input  logic        out_noise_active
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
    $stable(out_payload_bytes))
    else $error("result changed while stalled");

  a_noise_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_verdict == VERDICT_MEDIA) && !out_noise_active) ||
      (((out_verdict == VERDICT_CN_START) || (out_verdict == VERDICT_CN_ONGOING)) &&
       out_noise_active) ||
      (out_verdict == VERDICT_STUN) || (out_verdict == VERDICT_DROP))
    else $error("comfort noise state disagrees with verdict");

  a_non_media_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != VERDICT_MEDIA) |->
      (out_pl_offset == 7'd0) && (out_payload_bytes == 16'd0) && !out_seq_gap)
    else $error("non-media result carries payload fields");

  a_media_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_MEDIA) |->
      (out_pl_offset >= FIXED_HDR) && (out_pl_offset[1:0] == 2'b00))
    else $error("media payload offset out of range");

endmodule

bind rtp_receive_stats rtps_checker u_rtps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_verdict        (out_ch.verdict),
  .out_pl_offset      (out_ch.pl_offset),
  .out_payload_bytes  (out_ch.payload_bytes),
  .out_seq_gap        (out_ch.seq_gap),
  .out_noise_active   (out_ch.noise_active)
);

// ----- tb/rtps_stats_checker.sv -----
// ----------------------------------------------------------------------------
// RTP receive statistics checker
// Watches the header and result channels and the codec register port. Keeps
// its own copy of the loss, jitter and comfort-noise state, predicts the
// result of every accepted request and compares each returned result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rtps_stats_checker
  import rtps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  rtps_in_if          in_mon,
  rtps_out_if         out_mon,
  output int unsigned mismatch_count,
  output int unsigned outstanding
);

  typedef struct packed {
    verdict_t    verdict;
    logic [6:0]  pl_offset;
    logic [15:0] payload_bytes;
    logic        seq_gap;
    logic [31:0] jitter_estimate;
    logic [31:0] packet_count;
    logic [31:0] byte_count;
    logic [31:0] missing_count;
    logic        noise_active;
  } stats_res_t;

  logic [6:0]  codec_pt;
  logic [15:0] seq_prev;
  logic [31:0] last_ts;
  logic [31:0] last_ia;
  logic [31:0] jitter;
  logic [31:0] pkt_total;
  logic [31:0] byte_total;
  logic [31:0] loss_total;
  logic        cn_mode;

  stats_res_t  expected_q[$];
  stats_res_t  want;
  hdr_item_t   seen;

  initial mismatch_count = 0;
  initial outstanding    = 0;

  function automatic stats_res_t classify_packet(input hdr_item_t h);
    stats_res_t  r;
    logic [31:0] ia;
    logic [31:0] dev;
    logic [32:0] decay;
    logic [6:0]  off;
    r = '0;
    if (h.magic_word == STUN_COOKIE) begin
      r.verdict = VERDICT_STUN;
    end else if (h.pl_type != codec_pt) begin
      if (h.pl_type != CN_TYPE && h.pl_type != CN_TYPE_OLD) begin
        r.verdict = VERDICT_DROP;
      end else if (!cn_mode) begin
        cn_mode   = 1'b1;
        r.verdict = VERDICT_CN_START;
      end else begin
        r.verdict = VERDICT_CN_ONGOING;
      end
    end else begin
      r.verdict  = VERDICT_MEDIA;
      cn_mode    = 1'b0;
      pkt_total  = pkt_total + 32'd1;
      byte_total = byte_total + {16'd0, h.packet_len};
      if (seq_prev != SEQ_NONE && 16'(seq_prev + 16'd1) != h.seq_number) begin
        r.seq_gap  = 1'b1;
        loss_total = loss_total + 32'd1;
      end
      seq_prev = h.seq_number;
      if (last_ts != 32'd0) begin
        ia = h.rtp_timestamp - last_ts;
        if (last_ia != 32'd0) begin
          dev    = (ia < last_ia) ? last_ia - ia : ia - last_ia;
          decay  = ({1'b0, jitter} + 33'd8) >> 4;
          jitter = jitter + dev - decay[31:0];
        end
        last_ia = ia;
      end
      last_ts         = h.rtp_timestamp;
      off             = FIXED_HDR + {1'b0, h.csrc_count, 2'b00};
      r.pl_offset     = off;
      r.payload_bytes = (h.packet_len > {9'd0, off}) ? h.packet_len - {9'd0, off} : 16'd0;
    end
    r.jitter_estimate = jitter;
    r.packet_count    = pkt_total;
    r.byte_count      = byte_total;
    r.missing_count   = loss_total;
    r.noise_active    = cn_mode;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      codec_pt   = 7'd0;
      seq_prev   = SEQ_NONE;
      last_ts    = 32'd0;
      last_ia    = 32'd0;
      jitter     = 32'd0;
      pkt_total  = 32'd0;
      byte_total = 32'd0;
      loss_total = 32'd0;
      cn_mode    = 1'b0;
      expected_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        codec_pt = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        seen = {in_mon.magic_word, in_mon.pl_type, in_mon.seq_number,
                in_mon.rtp_timestamp, in_mon.csrc_count, in_mon.packet_len};
        expected_q.push_back(classify_packet(seen));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("Result returned with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("verdict", 32'(want.verdict), 32'(out_mon.verdict));
          check_field("pl_offset", 32'(want.pl_offset), 32'(out_mon.pl_offset));
          check_field("payload_bytes", 32'(want.payload_bytes),
                      32'(out_mon.payload_bytes));
          check_field("seq_gap", 32'(want.seq_gap), 32'(out_mon.seq_gap));
          check_field("jitter_estimate", want.jitter_estimate, out_mon.jitter_estimate);
          check_field("packet_count", want.packet_count, out_mon.packet_count);
          check_field("byte_count", want.byte_count, out_mon.byte_count);
          check_field("missing_count", want.missing_count, out_mon.missing_count);
          check_field("noise_active", 32'(want.noise_active), 32'(out_mon.noise_active));
        end
      end
      outstanding <= expected_q.size();
    end
  end

endmodule

// ----- tb/rtp_receive_stats_tb.sv -----
// ----------------------------------------------------------------------------
// RTP receive statistics testbench
// Drives parsed RTP headers into the block with random gaps and a random
// result stall, including one long hold-off that backs the block up. A short
// directed sequence covers the classification corner cases, wraps
// and jitter overflow, then media streams with losses, comfort-noise bursts,
// STUN requests and noise run under several codec settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rtp_receive_stats_tb;
  import rtps_pkg::*;

  localparam int unsigned PHASE_ITEMS    = 250;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  int unsigned mismatch_count;
  int unsigned outstanding;

  bit          src_idle;
  bit          snk_idle;
  bit          hold_req;
  logic [6:0]  codec_now;
  logic [15:0] stream_seq;
  logic [31:0] stream_ts;
  logic [31:0] frame_step;
  int unsigned cn_left;

  rtps_in_if  in_ch ();
  rtps_out_if out_ch ();

  rtp_receive_stats i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  rtps_stats_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic hdr_item_t mk_hdr(input logic [31:0] magic, input logic [6:0] pt,
                                       input logic [15:0] seq, input logic [31:0] ts,
                                       input logic [3:0] cc, input logic [15:0] len);
    hdr_item_t h;
    h.magic_word    = magic;
    h.pl_type       = pt;
    h.seq_number    = seq;
    h.rtp_timestamp = ts;
    h.csrc_count    = cc;
    h.packet_len    = len;
    return h;
  endfunction

  function automatic hdr_item_t random_hdr();
    hdr_item_t   h;
    int unsigned kind;
    int unsigned pick;
    h = mk_hdr($urandom, 7'($urandom_range(0, 127)), 16'($urandom), $urandom,
               4'($urandom_range(0, 15)), 16'($urandom));
    kind = (cn_left != 0) ? 75 : $urandom_range(0, 99);
    if (kind < 68) begin
      if ($urandom_range(0, 199) == 0) begin
        stream_seq = 16'($urandom);
        stream_ts  = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (pick < 90) stream_seq = stream_seq + 16'd1;
      else if (pick < 96) stream_seq = stream_seq + 16'($urandom_range(2, 6));
      else if (pick < 98) stream_seq = stream_seq;
      else stream_seq = 16'($urandom);
      if ($urandom_range(0, 49) == 0) stream_ts = $urandom;
      else stream_ts = stream_ts + frame_step + $urandom_range(0, 64) - 32'd32;
      h.pl_type       = codec_now;
      h.seq_number    = stream_seq;
      h.rtp_timestamp = stream_ts;
      if ($urandom_range(0, 3) != 0) h.csrc_count = 4'd0;
      if ($urandom_range(0, 9) != 0) begin
        h.packet_len = 16'(12 + 4 * h.csrc_count + $urandom_range(0, 320));
      end
    end else if (kind < 80) begin
      if (cn_left == 0) cn_left = $urandom_range(0, 5);
      else cn_left--;
      h.pl_type = $urandom_range(0, 1) ? CN_TYPE : CN_TYPE_OLD;
    end else if (kind < 86) begin
      h.magic_word = STUN_COOKIE;
    end
    return h;
  endfunction

  task automatic send_hdr(input hdr_item_t h);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.magic_word    <= h.magic_word;
    in_ch.pl_type       <= h.pl_type;
    in_ch.seq_number    <= h.seq_number;
    in_ch.rtp_timestamp <= h.rtp_timestamp;
    in_ch.csrc_count    <= h.csrc_count;
    in_ch.packet_len    <= h.packet_len;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_codec(input logic [6:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    codec_now = value;
  endtask

  initial begin : sink_side
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = snk_idle ? $urandom_range(0, 14) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned k;
    logic [6:0]  phase_codec;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= 7'd0;
    in_ch.valid         <= 1'b0;
    in_ch.magic_word    <= 32'd0;
    in_ch.pl_type       <= 7'd0;
    in_ch.seq_number    <= 16'd0;
    in_ch.rtp_timestamp <= 32'd0;
    in_ch.csrc_count    <= 4'd0;
    in_ch.packet_len    <= 16'd0;
    src_idle   = 1'b1;
    snk_idle   = 1'b1;
    hold_req   = 1'b0;
    codec_now  = 7'd0;
    stream_seq = 16'($urandom);
    stream_ts  = $urandom;
    frame_step = 32'd160;
    cn_left    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_codec(7'd0);
    send_hdr(mk_hdr(STUN_COOKIE, 7'd0, 16'd0, 32'd0, 4'd0, 16'd0));
    send_hdr(mk_hdr(32'hFFFF_FFFF, 7'd127, 16'hFFFF, 32'hFFFF_FFFF, 4'd15, 16'hFFFF));
    send_hdr(mk_hdr(32'd0, CN_TYPE, 16'd1, 32'd5, 4'd1, 16'd40));
    send_hdr(mk_hdr(32'd0, CN_TYPE_OLD, 16'd2, 32'd6, 4'd2, 16'd40));
    send_hdr(mk_hdr(STUN_COOKIE, CN_TYPE, 16'd3, 32'd7, 4'd3, 16'd40));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'hFFFE, 32'd0, 4'd0, 16'd0));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'hFFFF, 32'd100, 4'd15, 16'd72));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h0005, 32'd260, 4'd15, 16'd73));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h0006, 32'd420, 4'd0, 16'hFFFF));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h0009, 32'hFFFF_FF00, 4'd1, 16'd16));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h000A, 32'h0000_0050, 4'd2, 16'd20));
    send_hdr(mk_hdr(32'd0, CN_TYPE_OLD, 16'h000B, 32'd0, 4'd0, 16'd0));
    send_hdr(mk_hdr(32'h2112_A443, 7'd0, 16'h000B, 32'h0000_01F0, 4'd0, 16'd172));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h000C, 32'h0000_01F1, 4'd0, 16'd172));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h000D, 32'h8000_01F2, 4'd0, 16'd172));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h000E, 32'h8000_01F3, 4'd0, 16'd172));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h000F, 32'h0000_01F4, 4'd0, 16'd172));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h0010, 32'h0000_01F5, 4'd0, 16'd172));
    drain();

    write_codec(CN_TYPE);
    send_hdr(mk_hdr(32'd0, CN_TYPE, 16'h0011, 32'h0000_0300, 4'd0, 16'd100));
    send_hdr(mk_hdr(32'd0, CN_TYPE_OLD, 16'd0, 32'd0, 4'd0, 16'd100));
    send_hdr(mk_hdr(32'd0, CN_TYPE_OLD, 16'd0, 32'd0, 4'd0, 16'd100));
    send_hdr(mk_hdr(32'd0, CN_TYPE, 16'h0012, 32'h0000_0400, 4'd0, 16'd100));
    drain();

    write_codec(7'd127);
    send_hdr(mk_hdr(32'd0, 7'd127, 16'h0013, 32'h0000_0500, 4'd7, 16'd200));
    send_hdr(mk_hdr(32'd0, 7'd0, 16'h0014, 32'h0000_0600, 4'd0, 16'd200));
    send_hdr(mk_hdr(32'd0, CN_TYPE, 16'h0015, 32'h0000_0700, 4'd0, 16'd200));

    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: phase_codec = 7'd8;
        1: phase_codec = 7'd127;
        2: phase_codec = CN_TYPE;
        3: phase_codec = 7'd0;
        4: phase_codec = 7'($urandom_range(0, 127));
        default: phase_codec = CN_TYPE_OLD;
      endcase
      write_codec(phase_codec);
      case ($urandom_range(0, 3))
        0: frame_step = 32'd160;
        1: frame_step = 32'd320;
        2: frame_step = 32'd960;
        default: frame_step = $urandom_range(1, 100000);
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 64 == 0) begin
          src_idle = ($urandom_range(0, 3) != 0);
          snk_idle = ($urandom_range(0, 3) != 0);
        end
        if (p == 1 && k == 120) hold_req = 1'b1;
        send_hdr(random_hdr());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rtps_pkg.sv
hdl/rtps_in_if.sv
hdl/rtps_out_if.sv
hdl/rtps_in_reg.sv
hdl/rtps_core.sv
hdl/rtp_receive_stats.sv
hdl/rtps_checker.sv
tb/rtps_stats_checker.sv
tb/rtp_receive_stats_tb.sv
